FILE: src/scu_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sensor calibration unit.
// No dependencies.
package scu_pkg;

   localparam int QBITS = 13;           // quotient bits of the divider
   localparam int DW    = 29;           // dividend width after the range check
   localparam int NW    = 34;           // prepared numerator width

   localparam logic signed [16:0] TEMP_REF  = 17'sd250;
   localparam logic [30:0]        RECIP_K   = 31'd1099511627; // floor(2^40 / 1000)
   localparam int                 RECIP_SH  = 40;
   localparam logic [15:0]        THOUSAND  = 16'd1000;
   localparam logic [15:0]        ADC_FULL  = 16'd4095;
   localparam logic [15:0]        PCT_MAX   = 16'd100;
   localparam logic [15:0]        BATT_MAX  = 16'd5000;

   localparam logic [2:0] CSR_IS_CAL = 3'd0;
   localparam logic [2:0] CSR_DRY    = 3'd1;
   localparam logic [2:0] CSR_WET    = 3'd2;
   localparam logic [2:0] CSR_COEF   = 3'd3;
   localparam logic [2:0] CSR_OFFSET = 3'd4;
   localparam logic [2:0] CSR_SCALE  = 3'd5;

   typedef struct packed {
      logic        is_cal;
      logic [15:0] dry;
      logic [15:0] wet;
      logic [15:0] coef;
      logic [15:0] offset;
      logic [15:0] scale;
   } scu_cfg_type;

   typedef struct packed {
      logic        pass;
      logic        force0;
      logic        sat;
      logic        batt;
      logic [15:0] raw;
   } scu_tag_type;

endpackage

FILE: src/scu_front.sv
`timescale 1ns / 1ps
// Front stages: temperature term, battery product, numerator/divisor prep.
// Uses scu_pkg.
module scu_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  logic                in_kind,
   input  logic [15:0]         in_raw,
   input  logic [15:0]         in_temp,
   input  scu_pkg::scu_cfg_type cfg,
   output logic                out_valid,
   output logic [scu_pkg::DW-1:0] out_num,
   output logic [15:0]         out_den,
   output scu_pkg::scu_tag_type out_tag
);
   import scu_pkg::*;

   // stage A
   logic signed [16:0] tdiff;
   logic signed [32:0] tprod;
   logic signed [17:0] bsum;
   logic signed [34:0] bprod;
   logic               a_valid_ff;
   logic               a_kind_ff;
   logic [15:0]        a_raw_ff;
   logic               a_tneg_ff;
   logic [30:0]        a_tabs_ff;
   logic signed [34:0] a_bprod_ff;
   // stage B
   logic [61:0]        tmul;
   logic               b_valid_ff;
   logic               b_kind_ff;
   logic [15:0]        b_raw_ff;
   logic               b_tneg_ff;
   logic [30:0]        b_tabs_ff;
   logic [21:0]        b_q0_ff;
   logic signed [34:0] b_bprod_ff;
   // stage C
   logic [31:0]        q0x;
   logic [31:0]        rem;
   logic [21:0]        tq;
   logic signed [23:0] tc;
   logic signed [23:0] diff_in;
   logic               c_valid_ff;
   logic               c_kind_ff;
   logic [15:0]        c_raw_ff;
   logic signed [23:0] c_diff_ff;
   logic signed [34:0] c_bprod_ff;
   // stage D
   logic signed [30:0] mnum;
   logic signed [16:0] mrange;
   logic [NW-1:0]      num_sel;
   logic [15:0]        den_sel;
   logic               force0_sel;
   logic               pass_sel;
   logic [NW-1:0]      den_top;
   logic               d_valid_ff;
   logic [DW-1:0]      d_num_ff;
   logic [15:0]        d_den_ff;
   scu_tag_type        d_tag_ff;

   assign tdiff = $signed({in_temp[15], in_temp}) - TEMP_REF;
   assign tprod = tdiff * $signed(cfg.coef);
   assign bsum  = $signed({2'b00, in_raw}) + $signed({{2{cfg.offset[15]}}, cfg.offset});
   assign bprod = bsum * $signed({1'b0, cfg.scale});

   assign tmul = 62'(a_tabs_ff) * 62'(RECIP_K);

   assign q0x     = 32'(b_q0_ff) * 32'(THOUSAND);
   assign rem     = {1'b0, b_tabs_ff} - q0x;
   assign tq      = b_q0_ff + 22'(rem >= 32'(THOUSAND));
   assign tc      = b_tneg_ff ? -$signed({2'b00, tq}) : $signed({2'b00, tq});
   assign diff_in = $signed({8'd0, b_raw_ff}) + tc - $signed({8'd0, cfg.dry});

   assign mnum   = 31'(c_diff_ff) * 31'sd100;
   assign mrange = $signed({1'b0, cfg.wet}) - $signed({1'b0, cfg.dry});

   always_comb begin
      num_sel    = '0;
      den_sel    = 16'd1;
      force0_sel = 1'b0;
      pass_sel   = 1'b0;
      priority if (c_kind_ff && !cfg.is_cal) begin
         pass_sel = 1'b1;
      end else if (c_kind_ff) begin
         force0_sel = c_bprod_ff[34];
         num_sel    = c_bprod_ff[NW-1:0];
         den_sel    = THOUSAND;
      end else if (!cfg.is_cal) begin
         num_sel = NW'(c_raw_ff) * NW'(PCT_MAX);
         den_sel = ADC_FULL;
      end else begin
         num_sel    = mnum[30] ? NW'(-mnum) : NW'(mnum);
         den_sel    = (mrange == 17'sd0) ? 16'd1 :
                      (mrange[16] ? 16'(-mrange) : mrange[15:0]);
         force0_sel = mnum[30] ^ mrange[16];
      end
   end

   assign den_top = NW'({den_sel, {QBITS{1'b0}}});

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_kind_ff  <= in_kind;
         a_raw_ff   <= in_raw;
         a_tneg_ff  <= tprod[32];
         a_tabs_ff  <= tprod[32] ? 31'(-tprod) : tprod[30:0];
         a_bprod_ff <= bprod;

         b_kind_ff  <= a_kind_ff;
         b_raw_ff   <= a_raw_ff;
         b_tneg_ff  <= a_tneg_ff;
         b_tabs_ff  <= a_tabs_ff;
         b_q0_ff    <= tmul[RECIP_SH+21:RECIP_SH];
         b_bprod_ff <= a_bprod_ff;

         c_kind_ff  <= b_kind_ff;
         c_raw_ff   <= b_raw_ff;
         c_diff_ff  <= diff_in;
         c_bprod_ff <= b_bprod_ff;

         d_num_ff        <= num_sel[DW-1:0];
         d_den_ff        <= den_sel;
         d_tag_ff.pass   <= pass_sel;
         d_tag_ff.force0 <= force0_sel;
         d_tag_ff.sat    <= num_sel >= den_top;
         d_tag_ff.batt   <= c_kind_ff;
         d_tag_ff.raw    <= c_raw_ff;
      end
   end

   assign out_valid = d_valid_ff;
   assign out_num   = d_num_ff;
   assign out_den   = d_den_ff;
   assign out_tag   = d_tag_ff;

endmodule

FILE: src/scu_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage.
// Uses scu_pkg.
module scu_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  logic [scu_pkg::DW-1:0] in_num,
   input  logic [15:0]            in_den,
   input  scu_pkg::scu_tag_type   in_tag,
   output logic                   out_valid,
   output logic [scu_pkg::QBITS-1:0] out_quo,
   output scu_pkg::scu_tag_type   out_tag
);
   import scu_pkg::*;

   logic              v_ff   [QBITS];
   logic [DW-1:0]     rem_ff [QBITS];
   logic [QBITS-1:0]  quo_ff [QBITS];
   logic [15:0]       den_ff [QBITS];
   scu_tag_type       tag_ff [QBITS];

   logic [DW-1:0]     rem_src [QBITS];
   logic [QBITS-1:0]  quo_src [QBITS];
   logic [15:0]       den_src [QBITS];
   logic [DW-1:0]     rem_in  [QBITS];
   logic [QBITS-1:0]  quo_in  [QBITS];
   logic [DW:0]       sh      [QBITS];

   always_comb begin
      for (int i = 0; i < QBITS; i++) begin
         rem_src[i] = (i == 0) ? in_num : rem_ff[(i == 0) ? 0 : i-1];
         quo_src[i] = (i == 0) ? '0     : quo_ff[(i == 0) ? 0 : i-1];
         den_src[i] = (i == 0) ? in_den : den_ff[(i == 0) ? 0 : i-1];
         sh[i]      = (DW+1)'(den_src[i]) << (QBITS-1-i);
         rem_in[i]  = rem_src[i];
         quo_in[i]  = quo_src[i];
         if ({1'b0, rem_src[i]} >= sh[i]) begin
            rem_in[i]               = rem_src[i] - sh[i][DW-1:0];
            quo_in[i][QBITS-1-i]    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < QBITS; i++) v_ff[i] <= 1'b0;
      end else if (adv) begin
         for (int i = 0; i < QBITS; i++) v_ff[i] <= (i == 0) ? in_valid : v_ff[(i == 0) ? 0 : i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < QBITS; i++) begin
            rem_ff[i] <= rem_in[i];
            quo_ff[i] <= quo_in[i];
            den_ff[i] <= den_src[i];
            tag_ff[i] <= (i == 0) ? in_tag : tag_ff[(i == 0) ? 0 : i-1];
         end
      end
   end

   assign out_valid = v_ff[QBITS-1];
   assign out_quo   = quo_ff[QBITS-1];
   assign out_tag   = tag_ff[QBITS-1];

endmodule

FILE: src/sensor_calibration_unit.sv
`timescale 1ns / 1ps
// Top level: CSRs, front stages, divider, clamp and result register.
// Uses scu_pkg, scu_front, scu_div.
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_ready  req_kind, req_raw_value, req_temperature
//  rsp      out        rsp_valid/rsp_ready  rsp_result_value
//  csr      in         csr_we               csr_index, csr_wdata
//
// One beat per cycle unless rsp stalls; 4 front stages, 13 divider stages, 1 output.
// The divider's one-bit-per-stage chain sets the depth.
// Synchronous reset clears all valid bits and the CSRs to zero.
// A beat held at rsp stalls every stage in place; nothing is dropped or repeated.
module sensor_calibration_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [15:0] req_raw_value,
   input  logic [15:0] req_temperature,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_result_value,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import scu_pkg::*;

   scu_cfg_type      cfg_ff;
   logic             adv;
   logic             f_valid;
   logic [DW-1:0]    f_num;
   logic [15:0]      f_den;
   scu_tag_type      f_tag;
   logic             q_valid;
   logic [QBITS-1:0] q_quo;
   scu_tag_type      q_tag;
   logic [15:0]      limit;
   logic [15:0]      quo16;
   logic [15:0]      fin_value;
   logic             rsp_valid_ff;
   logic [15:0]      rsp_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IS_CAL: cfg_ff.is_cal <= csr_wdata[0];
            CSR_DRY:    cfg_ff.dry    <= csr_wdata;
            CSR_WET:    cfg_ff.wet    <= csr_wdata;
            CSR_COEF:   cfg_ff.coef   <= csr_wdata;
            CSR_OFFSET: cfg_ff.offset <= csr_wdata;
            CSR_SCALE:  cfg_ff.scale  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign adv       = !(rsp_valid_ff && !rsp_ready);
   assign req_ready = adv;

   scu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_kind   (req_kind),
      .in_raw    (req_raw_value),
      .in_temp   (req_temperature),
      .cfg       (cfg_ff),
      .out_valid (f_valid),
      .out_num   (f_num),
      .out_den   (f_den),
      .out_tag   (f_tag)
   );

   scu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (f_valid),
      .in_num    (f_num),
      .in_den    (f_den),
      .in_tag    (f_tag),
      .out_valid (q_valid),
      .out_quo   (q_quo),
      .out_tag   (q_tag)
   );

   assign limit = q_tag.batt ? BATT_MAX : PCT_MAX;
   assign quo16 = 16'(q_quo);

   always_comb begin
      priority if (q_tag.pass) begin
         fin_value = q_tag.raw;
      end else if (q_tag.force0) begin
         fin_value = '0;
      end else if (q_tag.sat || quo16 > limit) begin
         fin_value = limit;
      end else begin
         fin_value = quo16;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= q_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_value_ff <= fin_value;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;

`ifndef NO_ASSERTIONS
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("result valid right after reset");
   a_batt_clamp: assert property (@(posedge clock) disable iff (reset)
      q_valid && !q_tag.pass && q_tag.batt |-> fin_value <= BATT_MAX)
      else $error("battery result above clamp");
   a_pct_clamp: assert property (@(posedge clock) disable iff (reset)
      q_valid && !q_tag.batt |-> fin_value <= PCT_MAX)
      else $error("moisture result above clamp");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv && q_valid |=> $stable(q_valid) && $stable(q_quo))
      else $error("divider moved during stall");
`endif

endmodule
